FILE: rtl/button_press_order_tracker_unit_defines.svh
// Assertion macros shared by the button press order tracker.
`ifndef BUTTON_PRESS_ORDER_TRACKER_UNIT_DEFINES_SVH
`define BUTTON_PRESS_ORDER_TRACKER_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define BPOT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button tracker implication failed");

// Plain invariant checked on every rising clock edge outside reset.
`define BPOT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("button tracker invariant failed");

`endif

FILE: rtl/bpot_pkg.sv
`timescale 1ns / 1ps

package bpot_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int HIST_DEPTH  = 10;
    localparam int IDX_W       = 3;
    localparam int PIN_W       = 4;
    localparam int PINS        = 16;
    localparam int MAP_W       = 32;
    localparam int CNT_W       = $clog2(NUM_BUTTONS);
    localparam int LEN_W       = 4;
    localparam int ORDER_W     = NUM_BUTTONS * IDX_W;
    localparam int HIST_W      = HIST_DEPTH * IDX_W;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             compact;
        logic             append;
        logic             publish;
        logic [CNT_W-1:0] idx;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

FILE: rtl/bpot_ctrl.sv
`timescale 1ns / 1ps

module bpot_ctrl
    import bpot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPACT,
        ST_APPEND,
        ST_PUBLISH
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             w_last;

    assign w_last  = (r_cnt == CNT_W'(NUM_BUTTONS - 1));
    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == ST_IDLE) && i_valid;
        o_cmd.compact = (r_state == ST_COMPACT);
        o_cmd.append  = (r_state == ST_APPEND);
        o_cmd.publish = (r_state == ST_PUBLISH) && i_sts.out_free;
        o_cmd.idx     = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_valid) begin
                        r_state <= ST_COMPACT;
                    end
                end
                ST_COMPACT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_last) begin
                        r_state <= ST_PUBLISH;
                    end
                end
                ST_PUBLISH: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/bpot_dp.sv
`timescale 1ns / 1ps

module bpot_dp
    import bpot_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    input  logic                   i_cfg_we,
    input  logic [MAP_W-1:0]       i_cfg_data,
    input  logic [PINS-1:0]        i_pin_levels,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [NUM_BUTTONS-1:0] o_held_set,
    output logic [NUM_BUTTONS-1:0] o_newly_pressed,
    output logic [NUM_BUTTONS-1:0] o_newly_released,
    output logic [ORDER_W-1:0]     o_order_entries,
    output logic [LEN_W-1:0]       o_order_count,
    output logic [HIST_W-1:0]      o_history_entries,
    output logic [LEN_W-1:0]       o_history_count
);

    logic [MAP_W-1:0]       r_map;
    logic [NUM_BUTTONS-1:0] r_held;
    logic [NUM_BUTTONS-1:0] r_down;
    logic [NUM_BUTTONS-1:0] r_up;
    logic [IDX_W-1:0]       r_list [NUM_BUTTONS];
    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       r_wp;
    logic [IDX_W-1:0]       r_hist [HIST_DEPTH];
    logic [LEN_W-1:0]       r_hlen;
    logic                   r_out_valid;
    logic [NUM_BUTTONS-1:0] r_o_held;
    logic [NUM_BUTTONS-1:0] r_o_down;
    logic [NUM_BUTTONS-1:0] r_o_up;
    logic [ORDER_W-1:0]     r_o_order;
    logic [LEN_W-1:0]       r_o_olen;
    logic [HIST_W-1:0]      r_o_hist;
    logic [LEN_W-1:0]       r_o_hlen;

    logic [NUM_BUTTONS-1:0] n_held;
    logic [NUM_BUTTONS-1:0] w_chg;
    logic [IDX_W-1:0]       w_entry;
    logic                   w_keep;
    logic [ORDER_W-1:0]     n_order;
    logic [HIST_W-1:0]      n_hist;

    // A button whose map field lies beyond the register reads pin 0.
    always_comb begin
        logic [PIN_W-1:0] pin;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            pin = '0;
            if (PIN_W * b < MAP_W) begin
                pin = r_map[PIN_W*b +: PIN_W];
            end
            n_held[b] = ~i_pin_levels[pin];
        end
    end

    assign w_chg   = r_down | r_up;
    assign w_entry = r_list[i_cmd.idx];
    assign w_keep  = ({1'b0, i_cmd.idx} < r_len) && !w_chg[w_entry];

    always_comb begin
        n_order = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            if (LEN_W'(i) < r_wp) begin
                n_order[IDX_W*i +: IDX_W] = r_list[i];
            end
        end
        n_hist = '0;
        for (int i = 0; i < HIST_DEPTH; i++) begin
            if (LEN_W'(i) < r_hlen) begin
                n_hist[IDX_W*i +: IDX_W] = r_hist[i];
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map       <= '0;
            r_held      <= '0;
            r_len       <= '0;
            r_wp        <= '0;
            r_hlen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_map <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_held <= n_held;
                r_down <= n_held & ~r_held;
                r_up   <= r_held & ~n_held;
                r_wp   <= '0;
            end
            if (i_cmd.compact && w_keep) begin
                r_list[r_wp[CNT_W-1:0]] <= w_entry;
                r_wp <= r_wp + 1'b1;
            end
            if (i_cmd.append && r_down[i_cmd.idx]) begin
                if (r_wp < LEN_W'(NUM_BUTTONS)) begin
                    r_list[r_wp[CNT_W-1:0]] <= IDX_W'(i_cmd.idx);
                    r_wp <= r_wp + 1'b1;
                end
                if (r_hlen >= LEN_W'(HIST_DEPTH)) begin
                    for (int i = 0; i < HIST_DEPTH - 1; i++) begin
                        r_hist[i] <= r_hist[i+1];
                    end
                    r_hist[HIST_DEPTH-1] <= IDX_W'(i_cmd.idx);
                end else begin
                    for (int i = 0; i < HIST_DEPTH; i++) begin
                        if (LEN_W'(i) == r_hlen) begin
                            r_hist[i] <= IDX_W'(i_cmd.idx);
                        end
                    end
                    r_hlen <= r_hlen + 1'b1;
                end
            end
            if (i_cmd.publish) begin
                r_len       <= r_wp;
                r_out_valid <= 1'b1;
                r_o_held    <= r_held;
                r_o_down    <= r_down;
                r_o_up      <= r_up;
                r_o_order   <= n_order;
                r_o_olen    <= r_wp;
                r_o_hist    <= n_hist;
                r_o_hlen    <= r_hlen;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_held_set        = r_o_held;
    assign o_newly_pressed   = r_o_down;
    assign o_newly_released  = r_o_up;
    assign o_order_entries   = r_o_order;
    assign o_order_count     = r_o_olen;
    assign o_history_entries = r_o_hist;
    assign o_history_count   = r_o_hlen;

endmodule

FILE: rtl/button_press_order_tracker_unit.sv
`timescale 1ns / 1ps
// Channel   | Handshake                 | Word
// ----------+---------------------------+---------------------------------------------
// input     | i_valid / o_ready         | i_pin_levels
// output    | o_valid / i_ready         | held, pressed, released, order and history
// config    | i_cfg_valid / o_cfg_ready | i_cfg_data (button pin map)
//
// Each accepted word passes through a capture step, a walk that compacts the order
// list, a walk over the buttons that appends new presses, and a step that loads the
// output register.
// Reset is synchronous and active low; it empties the order list and the history,
// clears the previous held set and the pin map, and needs no clearing pass.
// A stalled output holds the block in its final step; the next input word is
// taken in the cycle after the result has moved into the output register.

`include "button_press_order_tracker_unit_defines.svh"

module button_press_order_tracker_unit
    import bpot_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [PINS-1:0]        i_pin_levels,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [NUM_BUTTONS-1:0] o_held_set,
    output logic [NUM_BUTTONS-1:0] o_newly_pressed,
    output logic [NUM_BUTTONS-1:0] o_newly_released,
    output logic [ORDER_W-1:0]     o_order_entries,
    output logic [LEN_W-1:0]       o_order_count,
    output logic [HIST_W-1:0]      o_history_entries,
    output logic [LEN_W-1:0]       o_history_count,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [MAP_W-1:0]       i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The pin map is a plain register, so a write is always taken.
    assign o_cfg_ready = 1'b1;

    // The controller sequences capture, compaction, append and publish.
    bpot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    // The datapath holds the map, the lists and the output register.
    bpot_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_pin_levels      (i_pin_levels),
        .i_out_ready       (i_ready),
        .o_out_valid       (o_valid),
        .o_held_set        (o_held_set),
        .o_newly_pressed   (o_newly_pressed),
        .o_newly_released  (o_newly_released),
        .o_order_entries   (o_order_entries),
        .o_order_count     (o_order_count),
        .o_history_entries (o_history_entries),
        .o_history_count   (o_history_count)
    );

    // A published order list holds as many entries as there are held buttons.
    `BPOT_ASSERT_IMP(a_order_matches_held, i_clk, i_rst_n, o_valid, $countones(o_held_set) == o_order_count)
    // A newly pressed button is held, a newly released one is not.
    `BPOT_ASSERT_IMP(a_edges_consistent, i_clk, i_rst_n, o_valid, ((o_newly_pressed & ~o_held_set) == '0) && ((o_newly_released & o_held_set) == '0))
    // A published history never holds more entries than its depth.
    `BPOT_ASSERT_ALWAYS(a_history_bound, i_clk, i_rst_n, !o_valid || (o_history_count <= LEN_W'(HIST_DEPTH)))
    // Once a result is published, it is valid and the block is back to ready for a new word.
    `BPOT_ASSERT_IMP(a_publish_then_idle, i_clk, i_rst_n, w_cmd.publish, ##1 o_valid && o_ready)

endmodule

FILE: verif/button_press_order_tracker_unit_tb.sv
`timescale 1ns / 1ps

module button_press_order_tracker_unit_tb;
    import bpot_pkg::*;

    // One report word as it leaves the block, one field per output port.
    typedef struct packed {
        logic [NUM_BUTTONS-1:0] held;
        logic [NUM_BUTTONS-1:0] pressed;
        logic [NUM_BUTTONS-1:0] released;
        logic [ORDER_W-1:0]     order;
        logic [LEN_W-1:0]       order_cnt;
        logic [HIST_W-1:0]      hist;
        logic [LEN_W-1:0]       hist_cnt;
    } t_tracker_report;

    // A directed step is either a pin map load or a pin word. Where the report can be
    // worked out by hand it is typed in here; every other word uses the predictor.
    typedef struct packed {
        logic            is_map;
        logic [MAP_W-1:0] value;
        logic            typed;
        t_tracker_report want;
    } t_directed_step;

    localparam int CYCLE_LIMIT     = 800000;
    localparam int RANDOM_PHASES   = 7;
    localparam int WORDS_PER_PHASE = 236;
    localparam int DRAIN_CYCLES    = 40;
    localparam int DIRECTED_STEPS  = 19;

    // With the reset map of zero every button reads pin 0, so an all-low word presses
    // all eight buttons at once in index order: 0,1,...,7 packed three bits each.
    localparam t_directed_step DIRECTED_TABLE [DIRECTED_STEPS] = '{
        // Reset map: nothing held, then everything, then nothing again.
        '{1'b0, 32'h0000FFFF, 1'b1, '{8'h00, 8'h00, 8'h00, 24'h000000, 4'd0,
                                      30'h00000000, 4'd0}},
        '{1'b0, 32'h00000000, 1'b1, '{8'hFF, 8'hFF, 8'h00, 24'hFAC688, 4'd8,
                                      30'h00FAC688, 4'd8}},
        '{1'b0, 32'h0000FFFF, 1'b1, '{8'h00, 8'h00, 8'hFF, 24'h000000, 4'd0,
                                      30'h00FAC688, 4'd8}},
        // Second full press overflows the history, so the oldest presses drop out.
        '{1'b0, 32'h0000FFFE, 1'b0, '0},
        '{1'b0, 32'h00000001, 1'b0, '0},
        // Button i reads pin i: presses out of index order build a 3,2,1 list.
        '{1'b1, 32'h76543210, 1'b0, '0},
        '{1'b0, 32'h0000FFF7, 1'b0, '0},
        '{1'b0, 32'h0000FFF3, 1'b0, '0},
        '{1'b0, 32'h0000FFF1, 1'b0, '0},
        '{1'b0, 32'h0000FFF5, 1'b0, '0},
        '{1'b0, 32'h0000FF00, 1'b0, '0},
        '{1'b0, 32'h0000FF7F, 1'b0, '0},
        '{1'b0, 32'h000000FF, 1'b0, '0},
        '{1'b0, 32'h0000FFFF, 1'b0, '0},
        // Every button reads the top pin.
        '{1'b1, 32'hFFFFFFFF, 1'b0, '0},
        '{1'b0, 32'h00007FFF, 1'b0, '0},
        '{1'b0, 32'h0000FFFF, 1'b0, '0},
        '{1'b0, 32'h00000000, 1'b0, '0},
        '{1'b0, 32'h00008000, 1'b0, '0}
    };

    logic                   i_clk;
    logic                   i_rst_n          = 1'b0;
    logic                   i_valid          = 1'b0;
    logic                   o_ready;
    logic [PINS-1:0]        i_pin_levels     = '1;
    logic                   o_valid;
    logic                   i_ready          = 1'b0;
    logic [NUM_BUTTONS-1:0] o_held_set;
    logic [NUM_BUTTONS-1:0] o_newly_pressed;
    logic [NUM_BUTTONS-1:0] o_newly_released;
    logic [ORDER_W-1:0]     o_order_entries;
    logic [LEN_W-1:0]       o_order_count;
    logic [HIST_W-1:0]      o_history_entries;
    logic [LEN_W-1:0]       o_history_count;
    logic                   i_cfg_valid      = 1'b0;
    logic                   o_cfg_ready;
    logic [MAP_W-1:0]       i_cfg_data       = '0;

    // Shadow copy of the tracker state, advanced once per accepted pin word.
    logic [MAP_W-1:0]       pin_map          = '0;
    logic [NUM_BUTTONS-1:0] prev_held        = '0;
    logic [IDX_W-1:0]       order_list [NUM_BUTTONS];
    int                     order_len        = 0;
    logic [IDX_W-1:0]       press_hist [HIST_DEPTH];
    int                     hist_len         = 0;

    t_tracker_report        reports_due [$];
    int                     mismatches       = 0;
    int                     words_sent       = 0;
    int                     reports_checked  = 0;
    int                     maps_loaded      = 0;
    int                     cycle_count      = 0;
    bit                     quiet_run        = 1'b0;

    button_press_order_tracker_unit dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pin_levels      (i_pin_levels),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_held_set        (o_held_set),
        .o_newly_pressed   (o_newly_pressed),
        .o_newly_released  (o_newly_released),
        .o_order_entries   (o_order_entries),
        .o_order_count     (o_order_count),
        .o_history_entries (o_history_entries),
        .o_history_count   (o_history_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Works out the report for one pin word and moves the shadow state forward.
    // Buttons that changed leave the order list first; new presses are then appended
    // in ascending index order and also pushed into the press history.
    function automatic t_tracker_report predict_tracker_report(input logic [PINS-1:0] pins);
        t_tracker_report        rep;
        logic [NUM_BUTTONS-1:0] held;
        logic [NUM_BUTTONS-1:0] down;
        logic [NUM_BUTTONS-1:0] up;
        logic [PIN_W-1:0]       pin;
        int                     wr;
        held = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            pin     = pin_map[PIN_W*b +: PIN_W];
            held[b] = ~pins[pin];
        end
        down = held & ~prev_held;
        up   = prev_held & ~held;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (up[b] || down[b]) begin
                wr = 0;
                for (int r = 0; r < order_len; r++) begin
                    if (order_list[r] != IDX_W'(b)) begin
                        order_list[wr] = order_list[r];
                        wr++;
                    end
                end
                order_len = wr;
            end
        end
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (down[b]) begin
                if (hist_len == HIST_DEPTH) begin
                    for (int k = 0; k < HIST_DEPTH - 1; k++) begin
                        press_hist[k] = press_hist[k+1];
                    end
                    hist_len--;
                end
                press_hist[hist_len] = IDX_W'(b);
                hist_len++;
                if (order_len < NUM_BUTTONS) begin
                    order_list[order_len] = IDX_W'(b);
                    order_len++;
                end
            end
        end
        prev_held = held;

        // Slots at or above the counts stay zero.
        rep          = '0;
        rep.held     = held;
        rep.pressed  = down;
        rep.released = up;
        for (int r = 0; r < order_len; r++) begin
            rep.order[IDX_W*r +: IDX_W] = order_list[r];
        end
        rep.order_cnt = LEN_W'(order_len);
        for (int r = 0; r < hist_len; r++) begin
            rep.hist[IDX_W*r +: IDX_W] = press_hist[r];
        end
        rep.hist_cnt = LEN_W'(hist_len);
        return rep;
    endfunction

    // Idle gaps and output stalls: mostly none, often short, now and then a
    // long one. During a quiet run both sides go flat out.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_run || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offers one pin word, waits for the handshake and queues the report it owes.
    task automatic send_pin_word(input logic [PINS-1:0] pins, input logic typed,
                                 input t_tracker_report want);
        int              gap;
        t_tracker_report predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_pin_levels <= pins;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_tracker_report(pins);
        reports_due.insert(reports_due.size(), typed ? want : predicted);
        words_sent++;
    endtask

    // The map is only loaded with the block idle: the sender stops and waits until
    // every report it owes has come back, then lets the pipeline settle.
    task automatic load_pin_map(input logic [MAP_W-1:0] map);
        i_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= map;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pin_map = map;
        maps_loaded++;
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // Output side: checks every accepted report word against the oldest one owed
    // and throws in stalls of random length on i_ready.
    initial begin : report_monitor
        t_tracker_report got;
        t_tracker_report want;
        int              stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.held      = o_held_set;
                got.pressed   = o_newly_pressed;
                got.released  = o_newly_released;
                got.order     = o_order_entries;
                got.order_cnt = o_order_count;
                got.hist      = o_history_entries;
                got.hist_cnt  = o_history_count;
                if (reports_due.size() == 0) begin
                    $display("%0t: report word with none expected, expected nothing, actual %h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = reports_due[0];
                    reports_due.delete(0);
                    check_field("held_set", 32'(want.held), 32'(got.held));
                    check_field("newly_pressed", 32'(want.pressed), 32'(got.pressed));
                    check_field("newly_released", 32'(want.released), 32'(got.released));
                    check_field("order_entries", 32'(want.order), 32'(got.order));
                    check_field("order_count", 32'(want.order_cnt), 32'(got.order_cnt));
                    check_field("history_entries", 32'(want.hist), 32'(got.hist));
                    check_field("history_count", 32'(want.hist_cnt), 32'(got.hist_cnt));
                    reports_checked++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // A run that never drains ends here.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: no progress after %0d cycles", $time, cycle_count);
        $display("** button_press_order_tracker_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        logic [PINS-1:0] pins;
        logic [PINS-1:0] last_pins;
        int              roll;
        int              btn;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int s = 0; s < DIRECTED_STEPS; s++) begin
            if (DIRECTED_TABLE[s].is_map) begin
                load_pin_map(DIRECTED_TABLE[s].value);
            end else begin
                send_pin_word(DIRECTED_TABLE[s].value[PINS-1:0], DIRECTED_TABLE[s].typed,
                              DIRECTED_TABLE[s].want);
            end
        end

        // Random phases, each under its own pin map. Most words toggle one or two
        // pins of the previous word, so buttons go down and up a few at a time and
        // the order list and history fill in many different orders; the rest are
        // fully random words, all-high and all-low words, and repeats.
        last_pins = '1;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            unique case (phase)
                0:       load_pin_map(32'h76543210);
                1:       load_pin_map(32'h01234567);
                2:       load_pin_map(32'hFEDCBA98);
                3:       load_pin_map(32'h00000000);
                4:       load_pin_map(32'hFFFFFFFF);
                default: load_pin_map($urandom);
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (n % 50 == 0) begin
                    quiet_run = ($urandom_range(0, 3) == 0);
                end
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    pins = last_pins ^ (16'h1 << $urandom_range(0, PINS - 1));
                    if ($urandom_range(0, 1) == 1) begin
                        pins ^= 16'h1 << $urandom_range(0, PINS - 1);
                    end
                end else if (roll < 65) begin
                    // Toggle the pin that some button actually reads.
                    btn  = $urandom_range(0, NUM_BUTTONS - 1);
                    pins = last_pins ^ (16'h1 << pin_map[PIN_W*btn +: PIN_W]);
                end else if (roll < 80) begin
                    pins = PINS'($urandom_range(0, 65535));
                end else if (roll < 87) begin
                    pins = '1;
                end else if (roll < 93) begin
                    pins = '0;
                end else begin
                    pins = last_pins;
                end
                send_pin_word(pins, 1'b0, '0);
                last_pins = pins;
            end
        end

        i_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d pin words under %0d pin map loads and checked %0d report words,",
                 words_sent, maps_loaded, reports_checked);
        $display("covering press order, releases and history overflow; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("** button_press_order_tracker_unit: PASSED **");
        end else begin
            $display("** button_press_order_tracker_unit: FAILED **");
        end
        $finish;
    end

endmodule
